// ===== design/fbsc_pkg.sv =====
// shared types and constants for the fat boot sector check pipeline
// no dependencies
package fbsc_pkg;

   localparam logic [15:0] SEC_MIN      = 16'd512;
   localparam logic [15:0] SEC_MAX      = 16'd4096;
   localparam logic [7:0]  MEDIA_FIXED  = 8'hF8;
   localparam logic [7:0]  MEDIA_REMOV  = 8'hF0;
   localparam logic [15:0] SIGNATURE    = 16'hAA55;
   localparam logic [31:0] LIMIT_FAT12  = 32'd4085;
   localparam logic [31:0] LIMIT_FAT16  = 32'd65525;
   localparam int          DIR_SHIFT    = 5;   // 32-byte directory entries
   localparam int          QUO_W        = 13;  // root directory sector quotient
   localparam int          DIV_STAGES   = 4;

   typedef enum logic [2:0] {
      ST_INVALID   = 3'd0,
      ST_FAT12     = 3'd1,
      ST_FAT16     = 3'd2,
      ST_FAT32     = 3'd3,
      ST_BAD_FAT32 = 3'd4,
      ST_UNDERFLOW = 3'd5
   } status_type;

   // request as it moves through the check and divider stages
   typedef struct packed {
      logic              valid;
      logic              ok;
      logic [15:0]       rsv;
      logic [39:0]       prod;
      logic [31:0]       tot;
      logic              fz16_nz;
      logic [2:0]        spc_log;
      logic [QUO_W-1:0]  divisor;
      logic [QUO_W-1:0]  rem;
      logic [QUO_W-1:0]  quo;
      logic [QUO_W-1:0]  dvd;
   } item_type;

   // request after the area sum
   typedef struct packed {
      logic              valid;
      logic              ok;
      logic              under;
      logic              fz16_nz;
      logic [2:0]        spc_log;
      logic [QUO_W-1:0]  rds;
      logic [31:0]       data;
   } sum_type;

endpackage

// ===== design/fbsc_check.sv =====
// first stage: field checks, field selection, fat area product, divider set-up
// depends on fbsc_pkg
module fbsc_check import fbsc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        enable,
   input  logic        in_valid,
   input  logic [15:0] bytes_per_sector,
   input  logic [7:0]  sectors_per_cluster,
   input  logic [15:0] reserved_sectors,
   input  logic [7:0]  fat_copies,
   input  logic [7:0]  media_byte,
   input  logic [15:0] total_sectors_small,
   input  logic [31:0] total_sectors_large,
   input  logic [15:0] fat_size_small,
   input  logic [31:0] fat_size_large,
   input  logic [15:0] root_entries,
   input  logic [15:0] boot_signature,
   output item_type    item
);

   item_type    item_ff, item_in;
   logic [31:0] fatsz;
   logic [21:0] dividend;
   logic [7:0]  spc_dec;
   logic        spc_ok;
   logic        media_ok;

   // parameter block checks
   always_comb begin
      spc_dec  = sectors_per_cluster - 8'd1;
      spc_ok   = (sectors_per_cluster != 8'd0) && ((sectors_per_cluster & spc_dec) == 8'd0);
      media_ok = (media_byte >= MEDIA_FIXED) || (media_byte == MEDIA_REMOV);
      fatsz    = (fat_size_small != 16'd0) ? {16'd0, fat_size_small} : fat_size_large;
      dividend = ({6'd0, root_entries} << DIR_SHIFT) + {6'd0, bytes_per_sector - 16'd1};

      item_in.valid   = in_valid;
      item_in.ok      = (bytes_per_sector >= SEC_MIN) && (bytes_per_sector <= SEC_MAX)
                        && spc_ok && (reserved_sectors != 16'd0) && (fat_copies != 8'd0)
                        && media_ok
                        && ((total_sectors_small != 16'd0) != (total_sectors_large != 32'd0))
                        && ((fat_size_small != 16'd0) || (fat_size_large != 32'd0))
                        && (boot_signature == SIGNATURE);
      item_in.rsv     = reserved_sectors;
      item_in.prod    = {32'd0, fat_copies} * {8'd0, fatsz};
      item_in.tot     = (total_sectors_small != 16'd0) ? {16'd0, total_sectors_small}
                                                       : total_sectors_large;
      item_in.fz16_nz = fat_size_small != 16'd0;
      case (sectors_per_cluster)
         8'd2:    item_in.spc_log = 3'd1;
         8'd4:    item_in.spc_log = 3'd2;
         8'd8:    item_in.spc_log = 3'd3;
         8'd16:   item_in.spc_log = 3'd4;
         8'd32:   item_in.spc_log = 3'd5;
         8'd64:   item_in.spc_log = 3'd6;
         8'd128:  item_in.spc_log = 3'd7;
         default: item_in.spc_log = 3'd0;
      endcase
      // the quotient fits in thirteen bits, so the top dividend bits start the remainder
      item_in.divisor = bytes_per_sector[QUO_W-1:0];
      item_in.rem     = {4'd0, dividend[21:QUO_W]};
      item_in.quo     = '0;
      item_in.dvd     = dividend[QUO_W-1:0];
   end

   // stage register
   always_ff @(posedge clock) begin
      if (reset) begin
         item_ff.valid <= 1'b0;
      end else if (enable) begin
         item_ff.valid <= item_in.valid;
      end
      if (enable) begin
         item_ff.ok      <= item_in.ok;
         item_ff.rsv     <= item_in.rsv;
         item_ff.prod    <= item_in.prod;
         item_ff.tot     <= item_in.tot;
         item_ff.fz16_nz <= item_in.fz16_nz;
         item_ff.spc_log <= item_in.spc_log;
         item_ff.divisor <= item_in.divisor;
         item_ff.rem     <= item_in.rem;
         item_ff.quo     <= item_in.quo;
         item_ff.dvd     <= item_in.dvd;
      end
   end

   assign item = item_ff;

endmodule

// ===== design/fbsc_divider.sv =====
// pipelined restoring divider for the root directory sectors, a few bits per stage
// depends on fbsc_pkg
module fbsc_divider import fbsc_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     enable,
   input  item_type item_i,
   output item_type item_o
);

   item_type stage_ff [DIV_STAGES];
   item_type stage_in [DIV_STAGES];

   // quotient bits per stage: four in the first, three in the rest
   always_comb begin
      for (int s = 0; s < DIV_STAGES; s++) begin
         logic [QUO_W:0] sh;
         item_type       cur;
         cur = (s == 0) ? item_i : stage_ff[s-1];
         for (int k = 0; k < 4; k++) begin
            if ((s == 0) || (k < 3)) begin
               sh = {cur.rem, cur.dvd[QUO_W-1]};
               cur.dvd = {cur.dvd[QUO_W-2:0], 1'b0};
               if (sh >= {1'b0, cur.divisor}) begin
                  sh      = sh - {1'b0, cur.divisor};
                  cur.quo = {cur.quo[QUO_W-2:0], 1'b1};
               end else begin
                  cur.quo = {cur.quo[QUO_W-2:0], 1'b0};
               end
               cur.rem = sh[QUO_W-1:0];
            end
         end
         stage_in[s] = cur;
      end
   end

   // stage registers
   always_ff @(posedge clock) begin
      for (int s = 0; s < DIV_STAGES; s++) begin
         if (reset) begin
            stage_ff[s].valid <= 1'b0;
         end else if (enable) begin
            stage_ff[s].valid <= stage_in[s].valid;
         end
         if (enable) begin
            stage_ff[s].ok      <= stage_in[s].ok;
            stage_ff[s].rsv     <= stage_in[s].rsv;
            stage_ff[s].prod    <= stage_in[s].prod;
            stage_ff[s].tot     <= stage_in[s].tot;
            stage_ff[s].fz16_nz <= stage_in[s].fz16_nz;
            stage_ff[s].spc_log <= stage_in[s].spc_log;
            stage_ff[s].divisor <= stage_in[s].divisor;
            stage_ff[s].rem     <= stage_in[s].rem;
            stage_ff[s].quo     <= stage_in[s].quo;
            stage_ff[s].dvd     <= stage_in[s].dvd;
         end
      end
   end

   assign item_o = stage_ff[DIV_STAGES-1];

endmodule

// ===== design/fbsc_classify.sv =====
// area sum, underflow test, cluster count shift and volume type, output register
// depends on fbsc_pkg
module fbsc_classify import fbsc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        enable,
   input  item_type    item,
   output logic        out_valid,
   output logic [2:0]  status,
   output logic [31:0] cluster_count,
   output logic [12:0] root_dir_sectors,
   output logic [31:0] data_sectors
);

   sum_type     sum_ff, sum_in;
   logic [40:0] used;
   logic        valid_ff;
   logic [2:0]  status_ff, status_in;
   logic [31:0] clus_ff, clus_in, data_ff, data_in;
   logic [12:0] rds_ff, rds_in;
   logic [31:0] clusters;

   // reserved plus fat plus root area, compared against the total
   always_comb begin
      used = {25'd0, item.rsv} + {1'b0, item.prod} + {28'd0, item.quo};
      sum_in.valid   = item.valid;
      sum_in.ok      = item.ok;
      sum_in.under   = used > {9'd0, item.tot};
      sum_in.fz16_nz = item.fz16_nz;
      sum_in.spc_log = item.spc_log;
      sum_in.rds     = item.quo;
      sum_in.data    = item.tot - used[31:0];
   end

   // cluster count and volume type
   always_comb begin
      clusters = sum_ff.data >> sum_ff.spc_log;
      status_in = ST_INVALID;
      clus_in   = '0;
      data_in   = '0;
      rds_in    = '0;
      if (sum_ff.ok) begin
         rds_in = sum_ff.rds;
         if (sum_ff.under) begin
            status_in = ST_UNDERFLOW;
         end else begin
            clus_in = clusters;
            data_in = sum_ff.data;
            if (clusters < LIMIT_FAT12) begin
               status_in = ST_FAT12;
            end else if (clusters < LIMIT_FAT16) begin
               status_in = ST_FAT16;
            end else if (sum_ff.fz16_nz) begin
               status_in = ST_BAD_FAT32;
            end else begin
               status_in = ST_FAT32;
            end
         end
      end
   end

   // stage and output registers
   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff.valid <= 1'b0;
         valid_ff     <= 1'b0;
      end else if (enable) begin
         sum_ff.valid <= sum_in.valid;
         valid_ff     <= sum_ff.valid;
      end
      if (enable) begin
         sum_ff.ok      <= sum_in.ok;
         sum_ff.under   <= sum_in.under;
         sum_ff.fz16_nz <= sum_in.fz16_nz;
         sum_ff.spc_log <= sum_in.spc_log;
         sum_ff.rds     <= sum_in.rds;
         sum_ff.data    <= sum_in.data;
         status_ff      <= status_in;
         clus_ff        <= clus_in;
         data_ff        <= data_in;
         rds_ff         <= rds_in;
      end
   end

   assign out_valid        = valid_ff;
   assign status           = status_ff;
   assign cluster_count    = clus_ff;
   assign root_dir_sectors = rds_ff;
   assign data_sectors     = data_ff;

endmodule

// ===== design/fat_boot_sector_check_and_type.sv =====
// top level of the fat boot sector check and volume type pipeline
// depends on fbsc_pkg, fbsc_check, fbsc_divider, fbsc_classify
//
// One request carries the fields of a boot sector parameter block on the req_
// channel (valid/ready). One result per request leaves on the rsp_ channel:
// the status code, cluster count, root directory sectors and data sectors.
// Throughput: one request per cycle while the output is not stalled. The request
// passes seven registers on its way to rsp_valid: the check stage,
// four divider stages for the root directory sectors (four, then three
// quotient bits each), the area sum stage and the output register.
// The whole pipeline advances together whenever the output register is empty
// or being taken; when the receiver holds rsp_ready low with a result waiting,
// every stage holds and req_ready is low, so nothing is lost or repeated.
// A synchronous reset clears all valid bits; the pipeline is empty after it.
module fat_boot_sector_check_and_type import fbsc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [15:0] req_bytes_per_sector,
   input  logic [7:0]  req_sectors_per_cluster,
   input  logic [15:0] req_reserved_sectors,
   input  logic [7:0]  req_fat_copies,
   input  logic [7:0]  req_media_byte,
   input  logic [15:0] req_total_sectors_small,
   input  logic [31:0] req_total_sectors_large,
   input  logic [15:0] req_fat_size_small,
   input  logic [31:0] req_fat_size_large,
   input  logic [15:0] req_root_entries,
   input  logic [15:0] req_boot_signature,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic [31:0] rsp_cluster_count,
   output logic [12:0] rsp_root_dir_sectors,
   output logic [31:0] rsp_data_sectors
);

   logic     enable;
   item_type chk_item, div_item;

   // global advance
   assign enable    = !rsp_valid || rsp_ready;
   assign req_ready = enable;

   fbsc_check u_check (
      .clock               (clock),
      .reset               (reset),
      .enable              (enable),
      .in_valid            (req_valid),
      .bytes_per_sector    (req_bytes_per_sector),
      .sectors_per_cluster (req_sectors_per_cluster),
      .reserved_sectors    (req_reserved_sectors),
      .fat_copies          (req_fat_copies),
      .media_byte          (req_media_byte),
      .total_sectors_small (req_total_sectors_small),
      .total_sectors_large (req_total_sectors_large),
      .fat_size_small      (req_fat_size_small),
      .fat_size_large      (req_fat_size_large),
      .root_entries        (req_root_entries),
      .boot_signature      (req_boot_signature),
      .item                (chk_item)
   );

   fbsc_divider u_divider (
      .clock  (clock),
      .reset  (reset),
      .enable (enable),
      .item_i (chk_item),
      .item_o (div_item)
   );

   fbsc_classify u_classify (
      .clock            (clock),
      .reset            (reset),
      .enable           (enable),
      .item             (div_item),
      .out_valid        (rsp_valid),
      .status           (rsp_status),
      .cluster_count    (rsp_cluster_count),
      .root_dir_sectors (rsp_root_dir_sectors),
      .data_sectors     (rsp_data_sectors)
   );

endmodule
